/* sv/hjsg_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hjsg_pkg
// Types, constants and helper functions of the Halton joint sample generator.
// ----------------------------------------------------------------------------
package hjsg_pkg;

	localparam int NUM_JOINTS = 5;
	localparam int JOINT_IDX_W = 3;
	localparam int DIGIT_W = 4;
	localparam int CHUNK_W = 8;
	localparam int ANGLE_W = 32;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 64;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_JOINT_LAST = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_START_INDEX = 3'd5;

	localparam logic [DIGIT_W-1:0] BASES [NUM_JOINTS] = '{4'd2, 4'd3, 4'd5, 4'd7, 4'd11};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_JSETUP,
		ST_DIGIT,
		ST_FRAC,
		ST_MLAST,
		ST_JFIN,
		ST_DONE
	} hjsg_state_t;

	// eight steps of long division by a small base, msb first
	// returns {remainder, quotient bits}
	function automatic logic [DIGIT_W+CHUNK_W-1:0] div_chunk(
		input logic [DIGIT_W-1:0] rem_in,
		input logic [CHUNK_W-1:0] bits,
		input logic [DIGIT_W-1:0] base
	);
		logic [DIGIT_W:0] r;
		logic [CHUNK_W-1:0] q;
		r = {1'b0, rem_in};
		q = '0;
		for (int i = CHUNK_W - 1; i >= 0; i--) begin
			r = {r[DIGIT_W-1:0], bits[i]};
			if (r >= {1'b0, base}) begin
				r = r - {1'b0, base};
				q[i] = 1'b1;
			end
		end
		return {r[DIGIT_W-1:0], q};
	endfunction

endpackage
`default_nettype wire

/* sv/halton_joint_sample_generator.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// halton_joint_sample_generator
// Five-joint Halton sample generator: radical inverse of the running index in
// bases 2, 3, 5, 7, 11, scaled into per-joint signed Q4.28 bounds.
// ----------------------------------------------------------------------------
//  channel  | handshake               | payload
//  ---------+-------------------------+----------------------------------------
//  input    | in_valid / in_ready     | final_in_batch
//  result   | out_valid / out_ready   | sample_number, angle_j0..4, batch_end
//  config   | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
//  an input is accepted only when idle, and no new input is taken until the
//    result is loaded; each joint runs setup, digit extraction in chunks of
//    8 bits (NCH = ceil(INDEX_BITS / 8) chunks), the fraction bits, a last
//    accumulate and the angle write; the result is loaded from the done state
//  one long-division unit (8 bits per cycle) extracts the digits, one
//    restoring divider yields one fraction bit per cycle, a shift-add
//    accumulator forms the scaled product behind it
//  reset clears counter, bounds and the state machine; config ready always high
//  a finished result waits in the output register; a new transaction is taken
//    meanwhile, and the next result waits until that register is free
// ----------------------------------------------------------------------------
module halton_joint_sample_generator #(
	parameter int INDEX_BITS = 32,
	parameter int FRACTION_BITS = 32
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic                                final_in_batch,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic [31:0]                              sample_number,
	output logic signed [hjsg_pkg::ANGLE_W-1:0]      angle_j0,
	output logic signed [hjsg_pkg::ANGLE_W-1:0]      angle_j1,
	output logic signed [hjsg_pkg::ANGLE_W-1:0]      angle_j2,
	output logic signed [hjsg_pkg::ANGLE_W-1:0]      angle_j3,
	output logic signed [hjsg_pkg::ANGLE_W-1:0]      angle_j4,
	output logic                                     batch_end,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [hjsg_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [hjsg_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import hjsg_pkg::*;

	localparam int NCH = (INDEX_BITS + CHUNK_W - 1) / CHUNK_W;
	localparam int DW = NCH * CHUNK_W;
	localparam int PW = INDEX_BITS + DIGIT_W;
	localparam int AW = FRACTION_BITS + ANGLE_W;
	localparam int CCW = $clog2(NCH + 1);
	localparam int FCW = $clog2(FRACTION_BITS);

	hjsg_state_t state_q, state_n;

	logic [CFG_DATA_W-1:0]   bounds_q [NUM_JOINTS];
	logic [INDEX_BITS-1:0]   sample_index_q;
	logic [INDEX_BITS-1:0]   idx_q;
	logic                    batch_q;
	logic [JOINT_IDX_W-1:0]  jidx_q;

	logic [DW-1:0]           work_q;
	logic [DIGIT_W-1:0]      drem_q;
	logic [CCW-1:0]          ccnt_q;
	logic [PW-1:0]           rev_q;
	logic [PW-1:0]           pw_q;
	logic [PW-1:0]           frem_q;
	logic [FCW-1:0]          fcnt_q;
	logic                    qbit_q;
	logic [AW-1:0]           acc_q;
	logic [ANGLE_W-1:0]      mag_q;
	logic                    neg_q;
	logic [ANGLE_W-1:0]      lower_q;
	logic [ANGLE_W-1:0]      ang_w_q [NUM_JOINTS];

	logic                    out_valid_q;
	logic [31:0]             out_num_q;
	logic [ANGLE_W-1:0]      out_ang_q [NUM_JOINTS];
	logic                    out_batch_q;

	logic                    in_acc;
	logic                    done_load;
	logic [DIGIT_W-1:0]      base;
	logic [DIGIT_W+CHUNK_W-1:0] chunk_res;
	logic [DIGIT_W-1:0]      drem_n;
	logic [DW-1:0]           work_n;
	logic                    last_chunk;
	logic [PW:0]             frem_dbl;
	logic                    fbit;
	logic [AW-1:0]           acc_n;
	logic [ANGLE_W:0]        span;
	logic [ANGLE_W-1:0]      q_hi;
	logic                    q_rem;
	logic [ANGLE_W-1:0]      offs;
	logic [ANGLE_W-1:0]      jval;
	logic [63:0]             idx_ext;

	// datapath
	assign base = BASES[jidx_q];
	assign chunk_res = div_chunk(drem_q, work_q[DW-1 -: CHUNK_W], base);
	assign drem_n = chunk_res[DIGIT_W+CHUNK_W-1:CHUNK_W];
	assign work_n = DW'({work_q, chunk_res[CHUNK_W-1:0]});
	assign last_chunk = (ccnt_q == CCW'(NCH - 1));

	assign frem_dbl = {frem_q, 1'b0};
	assign fbit = (frem_dbl >= {1'b0, pw_q});
	assign acc_n = AW'({acc_q, 1'b0}) + (qbit_q ? AW'(mag_q) : AW'(0));

	assign span = {bounds_q[jidx_q][63], bounds_q[jidx_q][63:32]}
		- {bounds_q[jidx_q][31], bounds_q[jidx_q][31:0]};

	assign q_hi = acc_q[AW-1:FRACTION_BITS];
	assign q_rem = |acc_q[FRACTION_BITS-1:0];
	assign offs = neg_q ? (ANGLE_W'(0) - (q_hi + ANGLE_W'(q_rem))) : q_hi;
	assign jval = lower_q + offs;

	assign idx_ext = 64'(idx_q);

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) state_n = ST_JSETUP;
			end
			ST_JSETUP: begin
				if (idx_q == '0) state_n = ST_FRAC;
				else state_n = ST_DIGIT;
			end
			ST_DIGIT: begin
				if (last_chunk && work_n == '0) state_n = ST_FRAC;
			end
			ST_FRAC: begin
				if (fcnt_q == FCW'(FRACTION_BITS - 1)) state_n = ST_MLAST;
			end
			ST_MLAST: state_n = ST_JFIN;
			ST_JFIN: begin
				if (jidx_q == JOINT_IDX_W'(NUM_JOINTS - 1)) state_n = ST_DONE;
				else state_n = ST_JSETUP;
			end
			ST_DONE: begin
				if (done_load) state_n = ST_IDLE;
			end
			default: state_n = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		in_ready = (state_q == ST_IDLE);
		done_load = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	end

	assign in_acc = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sample_index_q <= '0;
			jidx_q <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NUM_JOINTS; i++) bounds_q[i] <= '0;
		end else begin
			state_q <= state_n;
			if (in_acc) sample_index_q <= sample_index_q + INDEX_BITS'(1);
			if (cfg_valid && cfg_ready) begin
				if (cfg_index <= REG_JOINT_LAST)
					bounds_q[cfg_index] <= cfg_data;
				else if (cfg_index == REG_START_INDEX)
					sample_index_q <= INDEX_BITS'(cfg_data[31:0]);
			end
			if (state_q == ST_JFIN) begin
				if (jidx_q == JOINT_IDX_W'(NUM_JOINTS - 1)) jidx_q <= '0;
				else jidx_q <= jidx_q + JOINT_IDX_W'(1);
			end
			if (done_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			idx_q <= sample_index_q;
			batch_q <= final_in_batch;
		end
		case (state_q)
			ST_JSETUP: begin
				work_q <= DW'(idx_q);
				drem_q <= '0;
				ccnt_q <= '0;
				rev_q <= '0;
				pw_q <= PW'(1);
				frem_q <= '0;
				fcnt_q <= '0;
				qbit_q <= 1'b0;
				acc_q <= '0;
				neg_q <= span[ANGLE_W];
				mag_q <= span[ANGLE_W] ? ANGLE_W'(-span) : span[ANGLE_W-1:0];
				lower_q <= bounds_q[jidx_q][31:0];
			end
			ST_DIGIT: begin
				work_q <= work_n;
				if (last_chunk) begin
					drem_q <= '0;
					ccnt_q <= '0;
					rev_q <= PW'(rev_q * PW'(base)) + PW'(drem_n);
					pw_q <= PW'(pw_q * PW'(base));
					frem_q <= PW'(rev_q * PW'(base)) + PW'(drem_n);
				end else begin
					drem_q <= drem_n;
					ccnt_q <= ccnt_q + CCW'(1);
				end
			end
			ST_FRAC: begin
				frem_q <= fbit ? PW'(frem_dbl - {1'b0, pw_q}) : PW'(frem_dbl);
				qbit_q <= fbit;
				acc_q <= acc_n;
				fcnt_q <= fcnt_q + FCW'(1);
			end
			ST_MLAST: acc_q <= acc_n;
			ST_JFIN: ang_w_q[jidx_q] <= jval;
			default: begin
			end
		endcase
		if (done_load) begin
			out_num_q <= idx_ext[31:0];
			out_batch_q <= batch_q;
			for (int i = 0; i < NUM_JOINTS; i++) out_ang_q[i] <= ang_w_q[i];
		end
	end

	assign out_valid = out_valid_q;
	assign sample_number = out_num_q;
	assign angle_j0 = out_ang_q[0];
	assign angle_j1 = out_ang_q[1];
	assign angle_j2 = out_ang_q[2];
	assign angle_j3 = out_ang_q[3];
	assign angle_j4 = out_ang_q[4];
	assign batch_end = out_batch_q;

	// checks
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q == ST_JSETUP)
		else $error("accepted transaction did not start joint setup");

	a_counter_step: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && !(cfg_valid && cfg_index == REG_START_INDEX))
		|=> sample_index_q == $past(sample_index_q) + INDEX_BITS'(1))
		else $error("sample index did not advance");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result loaded outside done state");

	a_frac_rem: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FRAC |-> frem_q < pw_q)
		else $error("fraction remainder not below base power");

	a_digit_rem: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIGIT |-> drem_q < base)
		else $error("digit remainder not below base");

endmodule
`default_nettype wire
